@@ hw/rtl/tpd_pkg.sv @@
// Shared types and constants for the touch packet decoder.
// No dependencies; used by every module of the block.
package tpd_pkg;

  // Field and register widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 7;
  localparam int unsigned RawW   = 2 * DataW;
  localparam int unsigned DimW   = 13;
  localparam int unsigned XW     = 12;
  localparam int unsigned YW     = 13;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned ProdW  = RawW + DimW;

  // Byte layout
  localparam int unsigned HdrBit   = 7;
  localparam int unsigned TouchBit = 6;

  // Output limits
  localparam logic [DimW-1:0] XMax = DimW'(4095);
  localparam logic [DimW-1:0] YMax = DimW'(4096);

  // Register reset values
  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = CfgIdxW'(1);

  // Byte counter values inside a packet
  localparam logic [2:0] CntIdle = 3'd0;
  localparam logic [2:0] CntLast = 3'd4;

  // One assembled packet, handed from the parser to the scaler
  typedef struct packed {
    logic [RawW-1:0] raw_x;
    logic [RawW-1:0] raw_y;
    logic            touch;
  } pkt_t;

endpackage

@@ hw/rtl/tpd_scale.sv @@
// Coordinate scaler and result register of the touch packet decoder.
// Depends on tpd_pkg.
module tpd_scale
  import tpd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pkt_valid,
  input  pkt_t            pkt,
  output logic            pkt_adv,
  input  logic [DimW-1:0] screen_width,
  input  logic [DimW-1:0] screen_height,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [XW-1:0]   out_x_position,
  output logic [YW-1:0]   out_y_position,
  output logic            out_touched
);

  logic [ProdW-1:0] prod_x;
  logic [ProdW-1:0] prod_y;
  logic [DimW-1:0]  x_scaled;
  logic [DimW-1:0]  y_scaled;
  logic [DimW-1:0]  y_inv;
  logic [XW-1:0]    x_nxt;
  logic [YW-1:0]    y_nxt;
  logic             valid_r;
  logic             valid_nxt;
  logic [XW-1:0]    x_r;
  logic [YW-1:0]    y_r;
  logic             touch_r;

  // Scale raw coordinates, invert y, clamp to the output range
  always_comb begin
    prod_x   = ProdW'(pkt.raw_x) * ProdW'(screen_width);
    prod_y   = ProdW'(pkt.raw_y) * ProdW'(screen_height);
    x_scaled = prod_x[ProdW-1:RawW];
    y_scaled = prod_y[ProdW-1:RawW];
    // y_scaled never exceeds screen_height, so no wrap here
    y_inv    = screen_height - y_scaled;
    x_nxt    = (x_scaled > XMax) ? XMax[XW-1:0] : x_scaled[XW-1:0];
    y_nxt    = (y_inv > YMax) ? YMax[YW-1:0] : y_inv[YW-1:0];
  end

  // Result register takes a packet when empty or being drained
  assign pkt_adv   = !valid_r || !out_stall;
  assign valid_nxt = pkt_adv ? pkt_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_adv && pkt_valid) begin
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      touch_r <= pkt.touch;
    end
  end

  assign out_valid      = valid_r;
  assign out_x_position = x_r;
  assign out_y_position = y_r;
  assign out_touched    = touch_r;

endmodule

@@ hw/rtl/touch_packet_decoder_unit.sv @@
// Top level of the touch packet decoder: byte parser, packet register, config registers.
// Depends on tpd_pkg and tpd_scale.
//
// Takes one received byte per cycle. A byte with bit 7 set is a header and (re)starts a
// packet; bit 6 of it is the touch state. The next four bytes carry 7 data bits each,
// raw x low/high then raw y low/high. Bytes seen while no packet is open are dropped.
// On the fourth data byte one result is made: x = raw_x * width >> 14 (clamped to 4095)
// and y = height - (raw_y * height >> 14) (clamped to 4096). The result goes through the
// packet register and then the result register before it shows on the out_ port. The
// parser, the packet register and the result register each hold one entry, so a byte
// is taken every cycle as long as the result side drains; in_stall rises only when
// both registers are full and out_stall is high. The screen registers are always ready
// and should be written while no packet is in flight.
module touch_packet_decoder_unit
  import tpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ByteW-1:0]   in_rx_byte,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [XW-1:0]      out_x_position,
  output logic [YW-1:0]      out_y_position,
  output logic               out_touched,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DimW-1:0]    cfg_data
);

  logic [DimW-1:0]  width_r;
  logic [DimW-1:0]  height_r;
  logic [2:0]       count_r;
  logic [2:0]       count_nxt;
  logic             touch_r;
  logic             touch_nxt;
  logic [DataW-1:0] data_r [0:2];
  logic             pkt_valid_r;
  logic             pkt_valid_nxt;
  pkt_t             pkt_r;
  pkt_t             pkt_nxt;
  logic             pkt_adv;
  logic             in_take;
  logic             is_hdr;
  logic             pkt_done;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WidthReset;
      height_r <= HeightReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgScreenWidth:  width_r  <= cfg_data;
        CfgScreenHeight: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input handshake: stall only when the packet register cannot move on
  assign in_stall = pkt_valid_r && !pkt_adv;
  assign in_take  = in_valid && !in_stall;
  assign is_hdr   = in_rx_byte[HdrBit];
  assign pkt_done = in_take && !is_hdr && (count_r == CntLast);

  // Byte parser
  always_comb begin
    count_nxt = count_r;
    touch_nxt = touch_r;
    if (in_take) begin
      if (is_hdr) begin
        touch_nxt = in_rx_byte[TouchBit];
        count_nxt = 3'd1;
      end else if (count_r == CntIdle) begin
        count_nxt = CntIdle;
      end else if (count_r == CntLast) begin
        count_nxt = CntIdle;
      end else begin
        count_nxt = count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CntIdle;
      touch_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      touch_r <= touch_nxt;
    end
  end

  // Data byte store, first three data bytes of the packet
  always_ff @(posedge clk) begin
    if (in_take && !is_hdr && (count_r != CntIdle) && (count_r != CntLast)) begin
      data_r[2'(count_r - 3'd1)] <= in_rx_byte[DataW-1:0];
    end
  end

  // Packet register
  always_comb begin
    pkt_nxt.raw_x = {data_r[1], data_r[0]};
    pkt_nxt.raw_y = {in_rx_byte[DataW-1:0], data_r[2]};
    pkt_nxt.touch = touch_r;
    if (pkt_done) begin
      pkt_valid_nxt = 1'b1;
    end else if (pkt_adv) begin
      pkt_valid_nxt = 1'b0;
    end else begin
      pkt_valid_nxt = pkt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_valid_r <= 1'b0;
    end else begin
      pkt_valid_r <= pkt_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_done) begin
      pkt_r <= pkt_nxt;
    end
  end

  // Scaling and result register
  tpd_scale u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .pkt_valid      (pkt_valid_r),
    .pkt            (pkt_r),
    .pkt_adv        (pkt_adv),
    .screen_width   (width_r),
    .screen_height  (height_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_x_position (out_x_position),
    .out_y_position (out_y_position),
    .out_touched    (out_touched)
  );

endmodule

@@ hw/rtl/tpd_checker.sv @@
// Port-level checks for the touch packet decoder, bound to the top level.
// Depends on tpd_pkg.
module tpd_checker
  import tpd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [XW-1:0]      out_x_position,
  input logic [YW-1:0]      out_y_position,
  input logic               out_touched
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_position) &&
      $stable(out_y_position) && $stable(out_touched))
    else $error("result changed while stalled");

  // Input only backs up behind a blocked result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Inverted y never exceeds its clamp
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_y_position <= YMax[YW-1:0])
    else $error("y position out of range");

endmodule

bind touch_packet_decoder_unit tpd_checker u_tpd_checker (.*);
